// File: rtl/cctte_pkg.sv
package cctte_pkg;

  // field and register widths
  localparam int CURRENT_BITS = 20;
  localparam int CHARGE_BITS  = 48;
  localparam int TIME_BITS    = 32;
  localparam int CAP_BITS     = 20;
  localparam int PCT_BITS     = 7;
  localparam int TTE_BITS     = 27;
  localparam int CFG_BITS     = CAP_BITS;

  // shared multiplier
  localparam int MUL_BITS  = 32;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // intermediate widths
  localparam int SUM_BITS       = CURRENT_BITS + 1;
  localparam int SEED_PROD_BITS = CAP_BITS + PCT_BITS;
  localparam int CAPFULL_BITS   = CAP_BITS + 22;
  localparam int DIFF_BITS      = CHARGE_BITS + 2;

  // iterative divider
  localparam int DIVIDEND_BITS = CHARGE_BITS + 1;
  localparam int DIVISOR_BITS  = CURRENT_BITS;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

  localparam logic [MUL_BITS-1:0] SEED_SCALE  = 32'd36000;
  localparam logic [MUL_BITS-1:0] MS_PER_HOUR = 32'd3600000;
  localparam logic [TTE_BITS-1:0] DAY_MAX_MS  = 27'd86399999;
  localparam logic [PCT_BITS-1:0] PCT_FULL    = 7'd100;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 20'd123000;
  localparam logic [PCT_BITS-1:0] PCT_RESET = 7'd100;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_SOC      = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_A,
    ST_SEED_B,
    ST_INTEG,
    ST_CAP,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  // status returned by the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/cctte_mul.sv
module cctte_mul (
  input  logic                           clk_i,
  input  logic [cctte_pkg::MUL_BITS-1:0]  a_i,
  input  logic [cctte_pkg::MUL_BITS-1:0]  b_i,
  output logic [cctte_pkg::PROD_BITS-1:0] prod_o
);
  import cctte_pkg::*;

  logic [PROD_BITS-1:0] prod_q;
  logic [PROD_BITS-1:0] prod_d;

  assign prod_d = PROD_BITS'(a_i) * PROD_BITS'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/cctte_div.sv
module cctte_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [cctte_pkg::DIVIDEND_BITS-1:0] dividend_i,
  input  logic [cctte_pkg::DIVISOR_BITS-1:0]  divisor_i,
  output logic [cctte_pkg::DIVIDEND_BITS-1:0] quotient_o,
  output cctte_pkg::div_stat_t                stat_o
);
  import cctte_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DIV_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [DIVISOR_BITS-1:0]  rem_q;
  logic [DIVIDEND_BITS-1:0] quo_q;
  logic [DIVISOR_BITS-1:0]  den_q;

  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS+1:0] trial;
  logic                    fits;
  logic [DIVISOR_BITS-1:0] rem_next;

  // one restoring step: bring down the next dividend bit and try the subtract
  assign shifted  = {rem_q, quo_q[DIVIDEND_BITS-1]};
  assign trial    = {1'b0, shifted} - {2'b00, den_q};
  assign fits     = ~trial[DIVISOR_BITS+1];
  assign rem_next = fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/coulomb_counter_time_to_empty.sv
// sequence: integrate, capacity and prepare states, the divider when a division
// runs, then finish; on the first sample the seed states replace integrate
// throughput: one item at a time; the 49-step bit-serial divider sets the rate
// output register frees the next item while a result still waits for transfer
// reset: asynchronous active low; charge, prior sample and first-sample flag
// clear, capacity returns to 123000 mAh and start percent to 100
module coulomb_counter_time_to_empty (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  cctte_pkg::cfg_reg_e                cfg_idx_i,
  input  logic [cctte_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [cctte_pkg::CURRENT_BITS-1:0] current_ma_i,
  input  logic [cctte_pkg::TIME_BITS-1:0]    timestamp_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               charging_o,
  output logic signed [cctte_pkg::CHARGE_BITS-1:0] used_charge_ma_ms_o,
  output logic [cctte_pkg::TTE_BITS-1:0]     time_to_event_ms_o,
  output logic                               zero_current_o
);
  import cctte_pkg::*;

  // sequencer state
  state_e state_q, state_d;

  // configuration registers
  logic [CAP_BITS-1:0] cap_q;
  logic [PCT_BITS-1:0] pct_q;

  // integrator state
  logic                    seeded_q;
  logic                    seed_pass_q;
  logic [CHARGE_BITS-1:0]  used_q;
  logic [CURRENT_BITS-1:0] prior_cur_q;
  logic [TIME_BITS-1:0]    prior_time_q;

  // sample under work
  logic [CURRENT_BITS-1:0] cur_q;
  logic [TIME_BITS-1:0]    now_q;
  logic [DIVISOR_BITS-1:0] abs_cur_q;
  logic                    sum_neg_q;
  logic [TTE_BITS-1:0]     t_q;

  // result register
  logic                   out_valid_q;
  logic                   charging_q;
  logic                   zero_q;
  logic [CHARGE_BITS-1:0] used_out_q;
  logic [TTE_BITS-1:0]    t_out_q;

  // shared multiplier
  logic [MUL_BITS-1:0]  mul_a, mul_b;
  logic [PROD_BITS-1:0] prod;

  // divider
  logic                     div_start;
  logic [DIVIDEND_BITS-1:0] div_dividend;
  logic [DIVIDEND_BITS-1:0] div_quo;
  div_stat_t                div_stat;

  logic                    in_xfer;
  logic                    out_load;
  logic [PCT_BITS-1:0]     pct_clamp;
  logic [PCT_BITS-1:0]     pct_rest;
  logic [SUM_BITS-1:0]     cur_sum;
  logic [SUM_BITS-1:0]     abs_sum;
  logic [TIME_BITS-1:0]    dt;
  logic [CHARGE_BITS-1:0]  inc;
  logic [CHARGE_BITS-1:0]  used_integ;
  logic [CHARGE_BITS-1:0]  used_mag;
  logic [DIFF_BITS-1:0]    room;
  logic                    cur_zero;
  logic                    cur_neg;
  logic                    no_room;
  logic [TTE_BITS-1:0]     t_sat;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign cur_zero = (cur_q == '0);
  assign cur_neg  = cur_q[CURRENT_BITS-1];

  // a start percent above 100 counts as a full battery
  assign pct_clamp = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
  assign pct_rest  = PCT_FULL - pct_clamp;

  // trapezoid terms: signed sum of the two currents and the wrapped time step
  assign cur_sum = {prior_cur_q[CURRENT_BITS-1], prior_cur_q}
                 + {cur_q[CURRENT_BITS-1], cur_q};
  assign abs_sum = cur_sum[SUM_BITS-1] ? (SUM_BITS'(0) - cur_sum) : cur_sum;
  assign dt      = now_q - prior_time_q;

  // halving the magnitude truncates toward zero
  assign inc        = prod[CHARGE_BITS:1];
  assign used_integ = sum_neg_q ? (used_q - inc) : (used_q + inc);

  // time to full: |used| / |I|
  assign used_mag = used_q[CHARGE_BITS-1] ? (CHARGE_BITS'(0) - used_q) : used_q;
  // time to empty: (capacity in mA*ms - used) / I, nothing left when not positive
  assign room = {{(DIFF_BITS-CAPFULL_BITS){1'b0}}, prod[CAPFULL_BITS-1:0]}
              - {{(DIFF_BITS-CHARGE_BITS){used_q[CHARGE_BITS-1]}}, used_q};
  assign no_room = room[DIFF_BITS-1] | (room == '0);

  assign div_dividend = cur_neg ? {1'b0, used_mag} : room[DIVIDEND_BITS-1:0];

  // saturate the quotient to one day
  assign t_sat = (div_quo > {{(DIVIDEND_BITS-TTE_BITS){1'b0}}, DAY_MAX_MS})
               ? DAY_MAX_MS : div_quo[TTE_BITS-1:0];

  cctte_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  cctte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (abs_cur_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // sequencer: the multiplier is shared by the seed, the trapezoid and the
  // full-capacity product; its result shows up one state later
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = seeded_q ? ST_INTEG : ST_SEED_A;
        end
      end
      ST_SEED_A: begin
        // capacity times the missing percent
        mul_a   = {{(MUL_BITS-CAP_BITS){1'b0}}, cap_q};
        mul_b   = {{(MUL_BITS-PCT_BITS){1'b0}}, pct_rest};
        state_d = ST_SEED_B;
      end
      ST_SEED_B: begin
        // mAh per percent to mA*ms
        mul_a   = {{(MUL_BITS-SEED_PROD_BITS){1'b0}}, prod[SEED_PROD_BITS-1:0]};
        mul_b   = SEED_SCALE;
        state_d = ST_CAP;
      end
      ST_INTEG: begin
        mul_a   = {{(MUL_BITS-SUM_BITS){1'b0}}, abs_sum};
        mul_b   = dt;
        state_d = ST_CAP;
      end
      ST_CAP: begin
        // charge update happens here from the previous product
        mul_a   = {{(MUL_BITS-CAP_BITS){1'b0}}, cap_q};
        mul_b   = MS_PER_HOUR;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if (cur_zero || (!cur_neg && no_room)) begin
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      pct_q        <= PCT_RESET;
      seeded_q     <= 1'b0;
      seed_pass_q  <= 1'b0;
      used_q       <= '0;
      prior_cur_q  <= '0;
      prior_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAPACITY: cap_q <= cfg_wdata_i;
          REG_SOC:      pct_q <= cfg_wdata_i[PCT_BITS-1:0];
          default:      ;
        endcase
      end
      if (in_xfer) begin
        seed_pass_q <= ~seeded_q;
      end
      if (state_q == ST_CAP) begin
        used_q       <= seed_pass_q ? prod[CHARGE_BITS-1:0] : used_integ;
        prior_cur_q  <= cur_q;
        prior_time_q <= now_q;
        seeded_q     <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample payload and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_q     <= current_ma_i;
      now_q     <= timestamp_ms_i;
      abs_cur_q <= current_ma_i[CURRENT_BITS-1]
                 ? (DIVISOR_BITS'(0) - current_ma_i) : current_ma_i;
    end
    if (state_q == ST_INTEG) begin
      sum_neg_q <= cur_sum[SUM_BITS-1];
    end
    if (state_q == ST_PREP) begin
      t_q <= '0;
    end else if (state_q == ST_DIV && div_stat.done) begin
      t_q <= t_sat;
    end
    if (out_load) begin
      charging_q <= cur_neg;
      zero_q     <= cur_zero;
      used_out_q <= used_q;
      t_out_q    <= t_q;
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign charging_o          = charging_q;
  assign zero_current_o      = zero_q;
  assign used_charge_ma_ms_o = used_out_q;
  assign time_to_event_ms_o  = t_out_q;

  // a fresh result only comes from the finish state
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result loaded outside finish state");

  // the sequencer never waits on a divider that is idle
  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on idle divider");

  // zero current always reports zero time
  a_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zero_q) |-> (t_out_q == '0))
    else $error("zero current with nonzero time");

  // time never exceeds one day
  a_time_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (t_out_q <= DAY_MAX_MS))
    else $error("time to event above one day");

endmodule
